// ===== hw/rtl/scd_pkg.sv =====
// Shared types, command codes and helper functions of the SUMP command decoder.
package scd_pkg;

  localparam int TriggerStages = 4;

  // Command codes
  localparam logic [7:0] CmdReset     = 8'h00;
  localparam logic [7:0] CmdRun       = 8'h01;
  localparam logic [7:0] CmdId        = 8'h02;
  localparam logic [7:0] CmdMeta      = 8'h04;
  localparam logic [7:0] CmdDivider   = 8'h80;
  localparam logic [7:0] CmdCounts    = 8'h81;
  localparam logic [7:0] CmdFlags     = 8'h82;
  localparam logic [7:0] CmdTrigMask  = 8'hC0;
  localparam logic [7:0] CmdTrigValue = 8'hC1;
  localparam logic [7:0] CmdTrigSetup = 8'hC2;
  localparam logic [7:0] CmdStageMask = 8'hF3;
  localparam int         LongCmdBit   = 7;

  localparam logic [31:0] DividerMask = 32'h00ff_ffff;

  // Register indexes reported with a register update
  localparam logic [3:0] RegTrigMaskBase  = 4'd0;
  localparam logic [3:0] RegTrigValueBase = 4'd4;
  localparam logic [3:0] RegTrigSetupBase = 4'd8;
  localparam logic [3:0] RegDivider       = 4'd12;
  localparam logic [3:0] RegDelay         = 4'd13;
  localparam logic [3:0] RegRead          = 4'd14;
  localparam logic [3:0] RegFlags         = 4'd15;

  // Command queue between the parser and the result generator
  localparam int CmdQDepth = 4;
  localparam int CmdQPtrW  = $clog2(CmdQDepth);
  localparam int CmdQCntW  = $clog2(CmdQDepth + 1);

  typedef enum logic [2:0] {
    EV_REPLY = 3'd0,
    EV_RESET = 3'd1,
    EV_RUN   = 3'd2,
    EV_META  = 3'd3,
    EV_REG   = 3'd4
  } scd_event_t;

  typedef enum logic [2:0] {
    OP_RESET,
    OP_RUN,
    OP_ID,
    OP_META,
    OP_REG,
    OP_COUNTS
  } scd_op_t;

  typedef struct packed {
    scd_op_t     op;
    logic [3:0]  reg_index;
    logic [31:0] arg;
  } scd_cmd_t;

  // Characters of the identification reply, in order of transmission.
  function automatic logic [7:0] id_char(input logic [1:0] pos);
    logic [7:0] ch;
    unique case (pos)
      2'd0: ch = 8'h31;
      2'd1: ch = 8'h41;
      2'd2: ch = 8'h4C;
      2'd3: ch = 8'h53;
    endcase
    return ch;
  endfunction

  // Sample count in units of four samples: 4 * (field + 1).
  function automatic logic [31:0] count_value(input logic [15:0] field);
    logic [16:0] inc;
    inc = {1'b0, field} + 17'd1;
    return {13'd0, inc, 2'b00};
  endfunction

endpackage

// ===== hw/rtl/scd_front.sv =====
// Byte parser: gathers long-command arguments and classifies completed commands.
module scd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_valid,
  input  logic [7:0]       rx_byte,
  output logic             cmd_push,
  output scd_pkg::scd_cmd_t cmd
);
  import scd_pkg::*;

  logic        arg_phase_r, arg_phase_nxt;
  logic [7:0]  held_cmd_r, held_cmd_nxt;
  logic [1:0]  arg_cnt_r, arg_cnt_nxt;
  logic [23:0] arg_shift_r, arg_shift_nxt;

  logic [31:0] full_arg;
  logic [7:0]  base;
  logic [1:0]  stage;
  logic        stage_ok;

  assign full_arg = {arg_shift_r, rx_byte};
  assign base     = held_cmd_r & CmdStageMask;
  assign stage    = held_cmd_r[3:2];
  assign stage_ok = ({1'b0, stage} < 3'(TriggerStages));

  always_comb begin
    arg_phase_nxt = arg_phase_r;
    held_cmd_nxt  = held_cmd_r;
    arg_cnt_nxt   = arg_cnt_r;
    arg_shift_nxt = arg_shift_r;
    cmd_push      = 1'b0;
    cmd.op        = OP_RESET;
    cmd.reg_index = 4'd0;
    cmd.arg       = full_arg;

    if (byte_valid) begin
      if (!arg_phase_r) begin
        held_cmd_nxt = rx_byte;
        if (rx_byte[LongCmdBit]) begin
          arg_phase_nxt = 1'b1;
          arg_cnt_nxt   = 2'd0;
        end else begin
          cmd_push = 1'b1;
          unique case (rx_byte)
            CmdReset: cmd.op = OP_RESET;
            CmdRun:   cmd.op = OP_RUN;
            CmdId:    cmd.op = OP_ID;
            CmdMeta:  cmd.op = OP_META;
            default:  cmd_push = 1'b0;
          endcase
        end
      end else begin
        arg_shift_nxt = full_arg[23:0];
        arg_cnt_nxt   = arg_cnt_r + 2'd1;
        if (arg_cnt_r == 2'd3) begin
          arg_phase_nxt = 1'b0;
          cmd.op        = OP_REG;
          if (base == CmdTrigMask) begin
            cmd_push      = stage_ok;
            cmd.reg_index = RegTrigMaskBase + {2'b00, stage};
          end else if (base == CmdTrigValue) begin
            cmd_push      = stage_ok;
            cmd.reg_index = RegTrigValueBase + {2'b00, stage};
          end else if (base == CmdTrigSetup) begin
            cmd_push      = stage_ok;
            cmd.reg_index = RegTrigSetupBase + {2'b00, stage};
          end else if (held_cmd_r == CmdDivider) begin
            cmd_push      = 1'b1;
            cmd.reg_index = RegDivider;
            cmd.arg       = full_arg & DividerMask;
          end else if (held_cmd_r == CmdCounts) begin
            cmd_push      = 1'b1;
            cmd.op        = OP_COUNTS;
            cmd.reg_index = RegDelay;
          end else if (held_cmd_r == CmdFlags) begin
            cmd_push      = 1'b1;
            cmd.reg_index = RegFlags;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arg_phase_r <= 1'b0;
      held_cmd_r  <= 8'd0;
      arg_cnt_r   <= 2'd0;
      arg_shift_r <= 24'd0;
    end else begin
      arg_phase_r <= arg_phase_nxt;
      held_cmd_r  <= held_cmd_nxt;
      arg_cnt_r   <= arg_cnt_nxt;
      arg_shift_r <= arg_shift_nxt;
    end
  end

endmodule

// ===== hw/rtl/scd_cmd_queue.sv =====
// Small queue of decoded commands between the parser and the result generator.
module scd_cmd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  scd_pkg::scd_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output scd_pkg::scd_cmd_t head_cmd
);
  import scd_pkg::*;

  scd_cmd_t             mem_r [CmdQDepth];
  logic [CmdQPtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CmdQCntW-1:0]  count_r;
  logic                 do_push, do_pop;

  assign full       = (count_r == CmdQCntW'(CmdQDepth));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + CmdQPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + CmdQPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CmdQCntW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CmdQCntW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/scd_back.sv =====
// Result generator: expands each queued command into result items behind an output register.
module scd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  scd_pkg::scd_cmd_t head_cmd,
  output logic              cmd_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [2:0]        out_event_kind,
  output logic [7:0]        out_reply_byte,
  output logic [3:0]        out_reg_index,
  output logic [31:0]       out_reg_value,
  output logic              out_last
);
  import scd_pkg::*;

  logic [1:0]  beat_r;
  logic        out_valid_r;
  logic [2:0]  kind_r;
  logic [7:0]  reply_r;
  logic [3:0]  index_r;
  logic [31:0] value_r;
  logic        last_r;

  logic        adv;
  logic [2:0]  kind;
  logic [7:0]  reply;
  logic [3:0]  index;
  logic [31:0] value;
  logic        last_beat;

  assign adv     = head_valid && (!out_valid_r || out_pop);
  assign cmd_pop = adv && last_beat;

  always_comb begin
    kind      = EV_RESET;
    reply     = 8'd0;
    index     = 4'd0;
    value     = 32'd0;
    last_beat = 1'b1;
    unique case (head_cmd.op)
      OP_RESET: kind = EV_RESET;
      OP_RUN:   kind = EV_RUN;
      OP_META:  kind = EV_META;
      OP_ID: begin
        kind      = EV_REPLY;
        reply     = id_char(beat_r);
        last_beat = (beat_r == 2'd3);
      end
      OP_REG: begin
        kind  = EV_REG;
        index = head_cmd.reg_index;
        value = head_cmd.arg;
      end
      OP_COUNTS: begin
        kind = EV_REG;
        if (beat_r == 2'd0) begin
          index     = RegDelay;
          value     = count_value(head_cmd.arg[31:16]);
          last_beat = 1'b0;
        end else begin
          index = RegRead;
          value = count_value(head_cmd.arg[15:0]);
        end
      end
      default: kind = EV_RESET;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r  <= kind;
      reply_r <= reply;
      index_r <= index;
      value_r <= value;
      last_r  <= last_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        beat_r      <= last_beat ? 2'd0 : beat_r + 2'd1;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_event_kind = kind_r;
  assign out_reply_byte = reply_r;
  assign out_reg_index  = index_r;
  assign out_reg_value  = value_r;
  assign out_last       = last_r;

endmodule

// ===== hw/rtl/sump_command_decoder.sv =====
// Top level of the SUMP command decoder: parser, command queue and result generator.
//
// Usage: bytes received from the host link are offered on the input queue
// port. A request is taken at a rising edge with in_push high and in_full
// low. Each byte either completes a command or only advances the parser; a
// completed command that produces results is placed in a four-entry command
// queue, and in_full is high while that queue holds four commands.
// Results leave through the output queue port: while out_empty is low the
// oldest result is on the out_ ports, and it is taken at an edge with
// out_pop high. out_last marks the final result caused by one byte.
// A result caused by an accepted byte passes through the command queue and
// then the output register, whose load makes out_empty go low.
// Throughput: one byte per cycle is accepted while in_full is low, and one
// result per cycle is delivered while out_pop is high; the result generator
// emits the items of one command in order, four bytes for the identification
// reply, a delay and a read count update for counts, one for other commands.
// When the receiver stalls, the output register holds its result, the
// command queue fills behind it, and in_full then holds off the sender.
// Reset (rst_n low, synchronous) returns the parser to the command phase,
// empties the command queue and drops any pending result.
module sump_command_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_event_kind,
  output logic [7:0]  out_reply_byte,
  output logic [3:0]  out_reg_index,
  output logic [31:0] out_reg_value,
  output logic        out_last
);
  import scd_pkg::*;

  logic     byte_valid;
  logic     cmd_push;
  scd_cmd_t cmd;
  logic     q_full;
  logic     cmd_pop;
  logic     head_valid;
  scd_cmd_t head_cmd;

  // A byte is only taken when the queue can hold whatever command it completes.
  assign in_full    = q_full;
  assign byte_valid = in_push && !q_full;

  scd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .rx_byte    (in_rx_byte),
    .cmd_push   (cmd_push),
    .cmd        (cmd)
  );

  scd_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .full       (q_full),
    .pop        (cmd_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // The generator reads the queue head directly and frees the entry when it
  // loads the command's final result into its output register.
  scd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_cmd       (head_cmd),
    .cmd_pop        (cmd_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_event_kind (out_event_kind),
    .out_reply_byte (out_reply_byte),
    .out_reg_index  (out_reg_index),
    .out_reg_value  (out_reg_value),
    .out_last       (out_last)
  );

endmodule
